[design/srrip_pkg.sv]
// ----------------------------------------------------------------------------
// srrip_pkg
// Shared constants for the SRRIP replacement block: table geometry,
// re-reference prediction values and action codes.
// ----------------------------------------------------------------------------
`default_nettype none

package srrip_pkg;

  // table geometry
  localparam int FRAMES  = 64;
  localparam int FRAME_W = $clog2(FRAMES);
  localparam int COUNT_W = $clog2(FRAMES + 1);
  localparam int SCAN_W  = $clog2(3 * FRAMES + 2);
  localparam int RRPV_W  = 2;

  // re-reference prediction values
  localparam logic [RRPV_W-1:0] RRPV_NEAR = 2'd0;
  localparam logic [RRPV_W-1:0] RRPV_LONG = 2'd2;
  localparam logic [RRPV_W-1:0] RRPV_MAX  = 2'd3;

  // action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_HIT    = 2'd1;
  localparam logic [1:0] ACT_PICK   = 2'd2;

  // frame count after reset
  localparam logic [COUNT_W-1:0] FRAMES_IN_USE_RESET = COUNT_W'(FRAMES);

endpackage

`default_nettype wire

[design/srrip_replacement_top.sv]
// ----------------------------------------------------------------------------
// srrip_replacement_top
// SRRIP cache replacement: 2-bit re-reference prediction per frame in a
// synchronous memory, with a sweep hand that picks victims.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one action item: tuser holds the action code, tdata the
//   frame index. Insert and hit write the frame's value and give no result.
//   Pick victim sweeps the ring of frames in use,
//   one frame per cycle through the single read port of the table, and
//   returns the victim and the count of frames examined on m_axis.
//   A pick occupies the block from acceptance until the last of its k frames
//   is examined (k from 1 to 3*frames_in_use+1); its result is valid in the
//   cycle after the last frame is examined. No item is accepted during a
//   sweep.
//   cfg_we writes frames_in_use; write it only while the block is idle.
//   Reset: the table reads as all 3 at once (per-frame valid bits are
//   cleared, no clearing pass), the hand goes to 0, frames_in_use to 64.
//   Receiver stall: the result waits in the output register; inserts and
//   hits are still taken, a pick waits until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module srrip_replacement_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata,    // frames_in_use
  // action items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata, // [5:0] frame_index, [7:6] zero
  input  wire logic [1:0]  s_axis_tuser, // [1:0] action
  // victim results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata  // [5:0] victim_frame, [13:6] frames_scanned
);

  localparam int FW = srrip_pkg::FRAME_W;
  localparam int CW = srrip_pkg::COUNT_W;
  localparam int SW = srrip_pkg::SCAN_W;
  localparam int RW = srrip_pkg::RRPV_W;

  // states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic          state;
  logic [FW-1:0] hand;
  logic [CW-1:0] frames_cfg;
  logic [FW-1:0] cur;
  logic [SW-1:0] seen;

  // table memory and its valid bits
  logic [RW-1:0] mem [srrip_pkg::FRAMES];
  logic [srrip_pkg::FRAMES-1:0] valid;
  logic [RW-1:0] rd_data;
  logic          rd_vld;
  logic [FW-1:0] rd_addr;
  logic          wr_en;
  logic [FW-1:0] wr_addr;
  logic [RW-1:0] wr_data;

  // last write, for forwarding into the read that shares its edge
  logic          last_wr_en;
  logic [FW-1:0] last_wr_addr;
  logic [RW-1:0] last_wr_data;

  // output register
  logic [FW-1:0] victim;
  logic [SW-1:0] scanned;

  logic [CW-1:0] ring_n;
  logic [SW-1:0] limit;
  logic [FW-1:0] start;
  logic [FW-1:0] cur_wrap;
  logic [RW-1:0] cur_val;
  logic [SW-1:0] seen_inc;
  logic          found;
  logic          in_fire;
  logic          out_free;
  logic [1:0]    in_action;
  logic [FW-1:0] in_frame;

  // next frame on the ring
  function automatic logic [FW-1:0] ring_next(input logic [FW-1:0] f,
                                               input logic [CW-1:0] n);
    logic [CW-1:0] f1;
    f1 = CW'(f) + CW'(1);
    ring_next = (f1 >= n) ? '0 : f1[FW-1:0];
  endfunction

  assign in_action = s_axis_tuser;
  assign in_frame  = s_axis_tdata[FW-1:0];

  // ring size clamped to 1..FRAMES, and the sweep bound 3n+1
  always_comb begin
    if (frames_cfg == '0) begin
      ring_n = CW'(1);
    end else if (frames_cfg > CW'(srrip_pkg::FRAMES)) begin
      ring_n = CW'(srrip_pkg::FRAMES);
    end else begin
      ring_n = frames_cfg;
    end
    limit = SW'(({1'b0, ring_n} << 1) + {1'b0, ring_n} + (CW + 1)'(1));
  end

  assign start    = (CW'(hand) >= ring_n) ? '0 : hand;
  assign cur_wrap = ring_next(cur, ring_n);
  assign seen_inc = seen + SW'(1);

  // value of the frame under the hand, forwarded past a same-edge write
  always_comb begin
    if (last_wr_en && last_wr_addr == cur) begin
      cur_val = last_wr_data;
    end else if (rd_vld) begin
      cur_val = rd_data;
    end else begin
      cur_val = srrip_pkg::RRPV_MAX;
    end
  end

  assign found = (cur_val == srrip_pkg::RRPV_MAX) || (seen_inc == limit);

  // handshake
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) &&
                         ((in_action != srrip_pkg::ACT_PICK) || out_free);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // memory access control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = in_frame;
    wr_data = srrip_pkg::RRPV_LONG;
    rd_addr = start;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && in_action == srrip_pkg::ACT_INSERT) begin
          wr_en = 1'b1;
        end else if (in_fire && in_action == srrip_pkg::ACT_HIT) begin
          wr_en   = 1'b1;
          wr_data = srrip_pkg::RRPV_NEAR;
        end
      end
      ST_SCAN: begin
        rd_addr = cur_wrap;
        wr_addr = cur;
        wr_data = cur_val + RW'(1);
        wr_en   = (cur_val != srrip_pkg::RRPV_MAX);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // table storage with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // valid bits: an unwritten frame reads as the maximum value
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= valid[rd_addr];
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

  // forwarding register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_wr_en <= 1'b0;
    end else begin
      last_wr_en <= wr_en;
    end
    last_wr_addr <= wr_addr;
    last_wr_data <= wr_data;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_cfg <= srrip_pkg::FRAMES_IN_USE_RESET;
    end else if (cfg_we) begin
      frames_cfg <= cfg_wdata;
    end
  end

  // sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      hand          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire && in_action == srrip_pkg::ACT_PICK) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (found) begin
            state         <= ST_IDLE;
            hand          <= cur_wrap;
            m_axis_tvalid <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // sweep datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      cur  <= start;
      seen <= '0;
    end else begin
      cur  <= cur_wrap;
      seen <= seen_inc;
      if (found) begin
        victim  <= cur;
        scanned <= seen_inc;
      end
    end
  end

  assign m_axis_tdata = {(16 - FW - SW)'(0), scanned, victim};

endmodule

`default_nettype wire

[design/srrip_replacement_checker.sv]
// ----------------------------------------------------------------------------
// srrip_replacement_checker
// Port-level checks for the SRRIP replacement block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module srrip_replacement_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // no result right after reset
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // an insert or hit never raises a result
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid &&
    (s_axis_tuser == srrip_pkg::ACT_INSERT || s_axis_tuser == srrip_pkg::ACT_HIT)
    |=> !m_axis_tvalid)
    else $error("result without a pick");

  // a result appears only at the end of a sweep, when no item was taken
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result rose outside a sweep");

  // the scan count is never zero
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[13:6] != 8'd0)
    else $error("zero frames scanned");

endmodule

bind srrip_replacement_top srrip_replacement_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
